// File: design/ets_pkg.sv
// ets_pkg: shared types and constants for the extended timestamp one-shot timer
// used by ets_div and extended_timestamp_oneshot_timer; no dependencies
package ets_pkg;

  localparam int unsigned TIME_W        = 64;
  localparam int unsigned NPS_W         = 10;
  localparam int unsigned DELAY_W       = 24;
  localparam int unsigned CMD_W         = 2;
  localparam int unsigned NPS_RESET     = 200;
  localparam int unsigned NS_PER_HNSEC  = 100;
  localparam int unsigned FIRE_OFFSET   = 5;
  localparam int unsigned HNS_PER_US    = 10;
  localparam int unsigned SET_BIAS      = 1 * HNS_PER_US;
  localparam int unsigned ARM_MIN       = 2 * HNS_PER_US;
  localparam int unsigned DIV_STEP_W    = $clog2(TIME_W);

  // divide by 100 one 16-bit digit at a time; the remainder stays below 100
  localparam int unsigned HDIV_DIGIT_W  = 16;
  localparam int unsigned HDIV_REM_W    = 7;
  localparam int unsigned HDIV_N_W      = HDIV_REM_W + HDIV_DIGIT_W;
  // ceil(2^30 / 100), exact quotient for every 23-bit numerator below 100 * 2^16
  localparam int unsigned HDIV_REC      = 10737419;
  localparam int unsigned HDIV_REC_W    = 24;
  localparam int unsigned HDIV_SHIFT    = 30;
  localparam int unsigned HDIV_CYCLES   = 2 * TIME_W / HDIV_DIGIT_W;
  localparam int unsigned HDIV_CNT_W    = $clog2(HDIV_CYCLES);

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK   = 2'd0,
    CMD_SET    = 2'd1,
    CMD_CANCEL = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef struct packed {
    logic              start;
    logic [TIME_W-1:0] dividend;
    logic [NPS_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage

// File: design/ets_div.sv
// ets_div: iterative restoring divider, one quotient bit per cycle
// 64-bit dividend by 10-bit divisor; depends on ets_pkg
module ets_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ets_pkg::div_req_t             req,
  output ets_pkg::div_sts_t             sts,
  output logic [ets_pkg::TIME_W-1:0]    quotient
);

  logic [ets_pkg::TIME_W-1:0]     quo_r, quo_nxt;
  logic [ets_pkg::NPS_W-1:0]      rem_r, rem_nxt;
  logic [ets_pkg::NPS_W-1:0]      dvs_r, dvs_nxt;
  logic [ets_pkg::DIV_STEP_W-1:0] step_r, step_nxt;
  logic                           busy_r, busy_nxt;
  logic                           done_r, done_nxt;
  logic [ets_pkg::NPS_W:0]        trial;
  logic [ets_pkg::NPS_W:0]        diff;
  logic                           take;

  always_comb begin
    trial    = {rem_r, quo_r[ets_pkg::TIME_W-1]};
    diff     = trial - {1'b0, dvs_r};
    take     = (trial >= {1'b0, dvs_r});
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      quo_nxt  = req.dividend;
      rem_nxt  = '0;
      dvs_nxt  = req.divisor;
      step_nxt = ets_pkg::DIV_STEP_W'(ets_pkg::TIME_W - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      quo_nxt = {quo_r[ets_pkg::TIME_W-2:0], take};
      rem_nxt = take ? diff[ets_pkg::NPS_W-1:0] : trial[ets_pkg::NPS_W-1:0];
      if (step_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        step_nxt = step_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    quo_r  <= quo_nxt;
    rem_r  <= rem_nxt;
    dvs_r  <= dvs_nxt;
    step_r <= step_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign quotient = quo_r;

endmodule

// File: design/extended_timestamp_oneshot_timer.sv
// extended_timestamp_oneshot_timer: tick counter with 64-bit extended time and one-shot compare
// depends on ets_pkg and ets_div
//
//  channel | direction | handshake            | payload
//  in      | input     | in_valid / in_ready   | in_command, in_delay_value
//  out     | output    | out_valid / out_ready | out_now_time, out_fired, out_fire_time
//  cfg     | input     | cfg_valid / cfg_ready | cfg_nanosec_per_tick
//
// tick, cancel and none commands run ST_MUL (shift-add of time times resolution), ST_NDIV
// (division by 100, a quotient and a remainder step per 16-bit digit) and ST_DONE, which
// fills the result register once it is free; one transaction is in flight at a time.
// Set commands first wait in ST_TDIV: the serial divider first turns the delay into ticks
// in_ready is high only while the sequencer is idle and no cfg write is offered; cfg_ready
// is high while idle; the result register lets the next transaction in while a result waits
// reset (rst_n low, synchronous) clears counter, extended total, arm flag; resolution is 200
module extended_timestamp_oneshot_timer #(
  parameter int unsigned COUNTER_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [ets_pkg::CMD_W-1:0]             in_command,
  input  logic signed [ets_pkg::DELAY_W-1:0]    in_delay_value,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [ets_pkg::TIME_W-1:0]            out_now_time,
  output logic                                  out_fired,
  output logic [ets_pkg::TIME_W-1:0]            out_fire_time,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [ets_pkg::NPS_W-1:0]             cfg_nanosec_per_tick
);

  localparam int unsigned OVF_W  = ets_pkg::TIME_W - COUNTER_BITS;
  localparam int unsigned MCNT_W = $clog2(ets_pkg::NPS_W);
  localparam int unsigned DM_W   = ets_pkg::DELAY_W + 1;
  localparam int unsigned SD_W   = ets_pkg::DELAY_W + 7;
  localparam int unsigned HP_W   = ets_pkg::HDIV_N_W + ets_pkg::HDIV_REC_W;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_TDIV = 5'b00010,
    ST_MUL  = 5'b00100,
    ST_NDIV = 5'b01000,
    ST_DONE = 5'b10000
  } state_t;

  state_t                          state_r, state_nxt;
  logic [COUNTER_BITS-1:0]         cnt_r, cnt_nxt;
  logic [OVF_W-1:0]                ovf_r, ovf_nxt;
  logic [COUNTER_BITS-1:0]         cmp_r, cmp_nxt;
  logic                            arm_r, arm_nxt;
  logic [ets_pkg::NPS_W-1:0]       nps_r, nps_nxt;
  logic                            fire_r, fire_nxt;
  logic                            set_arm_r, set_arm_nxt;
  logic [ets_pkg::TIME_W-1:0]      prod_r, prod_nxt;
  logic [ets_pkg::TIME_W-1:0]      mcand_r, mcand_nxt;
  logic [ets_pkg::NPS_W-1:0]       mplier_r, mplier_nxt;
  logic [MCNT_W-1:0]               mcnt_r, mcnt_nxt;
  logic [ets_pkg::TIME_W-1:0]      now_r, now_nxt;
  logic [ets_pkg::HDIV_REM_W-1:0]  hrem_r, hrem_nxt;
  logic [ets_pkg::HDIV_DIGIT_W-1:0] hq_r, hq_nxt;
  logic [ets_pkg::HDIV_CNT_W-1:0]  hcnt_r, hcnt_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic [ets_pkg::TIME_W-1:0]      out_now_r, out_now_nxt;
  logic                            out_fired_r, out_fired_nxt;
  logic [ets_pkg::TIME_W-1:0]      out_ft_r, out_ft_nxt;

  ets_pkg::div_req_t               div_req;
  ets_pkg::div_sts_t               div_sts;
  logic [ets_pkg::TIME_W-1:0]      div_quo;

  logic                            in_acc;
  ets_pkg::cmd_t                   cmd;
  logic signed [DM_W-1:0]          dm;
  logic [ets_pkg::DELAY_W-1:0]     d_adj;
  logic [SD_W-1:0]                 scaled;
  logic [COUNTER_BITS-1:0]         ticks;
  logic [ets_pkg::HDIV_N_W-1:0]    hnum;
  logic [HP_W-1:0]                 hprod;
  logic [ets_pkg::HDIV_N_W-1:0]    hsub;
  logic [ets_pkg::HDIV_N_W-1:0]    hdiff;

  ets_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_req),
    .sts      (div_sts),
    .quotient (div_quo)
  );

  assign in_ready  = (state_r == ST_IDLE) && !cfg_valid;
  assign in_acc    = in_valid && in_ready;
  assign cfg_ready = (state_r == ST_IDLE);
  assign cmd       = ets_pkg::cmd_t'(in_command);

  always_comb begin
    dm     = DM_W'(in_delay_value) - DM_W'(ets_pkg::SET_BIAS);
    d_adj  = dm[DM_W-1] ? '0 : dm[ets_pkg::DELAY_W-1:0];
    scaled = SD_W'(d_adj) * SD_W'(ets_pkg::NS_PER_HNSEC);
    ticks  = (div_quo[ets_pkg::TIME_W-1:COUNTER_BITS] != '0) ? '1
           : div_quo[COUNTER_BITS-1:0];
    hnum   = {hrem_r, prod_r[ets_pkg::TIME_W-1 -: ets_pkg::HDIV_DIGIT_W]};
    hprod  = HP_W'(hnum) * HP_W'(ets_pkg::HDIV_REC);
    hsub   = ets_pkg::HDIV_N_W'(hq_r) * ets_pkg::HDIV_N_W'(ets_pkg::NS_PER_HNSEC);
    hdiff  = hnum - hsub;
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    ovf_nxt       = ovf_r;
    cmp_nxt       = cmp_r;
    arm_nxt       = arm_r;
    nps_nxt       = nps_r;
    fire_nxt      = fire_r;
    set_arm_nxt   = set_arm_r;
    prod_nxt      = prod_r;
    mcand_nxt     = mcand_r;
    mplier_nxt    = mplier_r;
    mcnt_nxt      = mcnt_r;
    now_nxt       = now_r;
    hrem_nxt      = hrem_r;
    hq_nxt        = hq_r;
    hcnt_nxt      = hcnt_r;
    out_valid_nxt = out_valid_r;
    out_now_nxt   = out_now_r;
    out_fired_nxt = out_fired_r;
    out_ft_nxt    = out_ft_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cfg_valid && cfg_ready) begin
      nps_nxt = cfg_nanosec_per_tick;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          fire_nxt   = 1'b0;
          prod_nxt   = '0;
          mcnt_nxt   = MCNT_W'(ets_pkg::NPS_W - 1);
          state_nxt  = ST_MUL;
          unique case (cmd)
            ets_pkg::CMD_TICK: begin
              cnt_nxt = cnt_r + 1'b1;
              if (cnt_nxt == '0) begin
                ovf_nxt = ovf_r + 1'b1;
              end
              if (arm_r && (cnt_nxt == cmp_r)) begin
                arm_nxt  = 1'b0;
                fire_nxt = 1'b1;
              end
            end
            ets_pkg::CMD_SET: begin
              set_arm_nxt = (d_adj > ets_pkg::DELAY_W'(ets_pkg::ARM_MIN));
              state_nxt   = ST_TDIV;
            end
            ets_pkg::CMD_CANCEL: begin
              arm_nxt = 1'b0;
            end
            ets_pkg::CMD_NONE: begin
            end
            default: begin
            end
          endcase
          mcand_nxt  = {ovf_nxt, cnt_nxt};
          mplier_nxt = nps_nxt;
        end
      end
      ST_TDIV: begin
        if (div_sts.done) begin
          if (set_arm_r) begin
            cmp_nxt = cnt_r + ticks;
            arm_nxt = 1'b1;
          end else begin
            arm_nxt  = 1'b0;
            fire_nxt = 1'b1;
          end
          mplier_nxt = nps_r;
          state_nxt  = ST_MUL;
        end
      end
      ST_MUL: begin
        if (mplier_r[0]) begin
          prod_nxt = prod_r + mcand_r;
        end
        mcand_nxt  = {mcand_r[ets_pkg::TIME_W-2:0], 1'b0};
        mplier_nxt = {1'b0, mplier_r[ets_pkg::NPS_W-1:1]};
        if (mcnt_r == '0) begin
          hrem_nxt  = '0;
          hcnt_nxt  = '0;
          state_nxt = ST_NDIV;
        end else begin
          mcnt_nxt = mcnt_r - 1'b1;
        end
      end
      ST_NDIV: begin
        if (!hcnt_r[0]) begin
          hq_nxt = hprod[ets_pkg::HDIV_SHIFT +: ets_pkg::HDIV_DIGIT_W];
        end else begin
          hrem_nxt = hdiff[ets_pkg::HDIV_REM_W-1:0];
          now_nxt  = {now_r[ets_pkg::TIME_W-ets_pkg::HDIV_DIGIT_W-1:0], hq_r};
          prod_nxt = prod_r << ets_pkg::HDIV_DIGIT_W;
        end
        if (hcnt_r == ets_pkg::HDIV_CNT_W'(ets_pkg::HDIV_CYCLES - 1)) begin
          state_nxt = ST_DONE;
        end else begin
          hcnt_nxt = hcnt_r + 1'b1;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_now_nxt   = now_r;
          out_fired_nxt = fire_r;
          out_ft_nxt    = fire_r ? (now_r - ets_pkg::TIME_W'(ets_pkg::FIRE_OFFSET)) : '0;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    div_req.start    = in_acc && (cmd == ets_pkg::CMD_SET);
    div_req.dividend = ets_pkg::TIME_W'(scaled);
    div_req.divisor  = nps_nxt;
  end

  always_ff @(posedge clk) begin
    cmp_r     <= cmp_nxt;
    set_arm_r <= set_arm_nxt;
    prod_r    <= prod_nxt;
    mcand_r   <= mcand_nxt;
    mplier_r  <= mplier_nxt;
    mcnt_r    <= mcnt_nxt;
    now_r     <= now_nxt;
    hrem_r    <= hrem_nxt;
    hq_r      <= hq_nxt;
    hcnt_r    <= hcnt_nxt;
    fire_r    <= fire_nxt;
    out_now_r <= out_now_nxt;
    out_fired_r <= out_fired_nxt;
    out_ft_r  <= out_ft_nxt;
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      ovf_r       <= '0;
      arm_r       <= 1'b0;
      nps_r       <= ets_pkg::NPS_W'(ets_pkg::NPS_RESET);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      ovf_r       <= ovf_nxt;
      arm_r       <= arm_nxt;
      nps_r       <= nps_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_now_time  = out_now_r;
  assign out_fired     = out_fired_r;
  assign out_fire_time = out_ft_r;

endmodule
